### src/mge_pkg.sv
// Package with the shared types and constants of the membership gossip engine.
`default_nettype none
package mge_pkg;
    localparam int NODES = 16;
    localparam int SLOTS = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int NODE_W = $clog2(NODES);
    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int FILL_LIM = (SLOTS < 8) ? SLOTS : 8;
    localparam int FCNT_W = $clog2(FILL_LIM + 1);
    localparam logic [7:0] NO_NODE = 8'hFF;
    localparam logic [3:0] TTL_AT_RESET = 4'd6;

    localparam logic [2:0] CMD_RUMOR = 3'd0;
    localparam logic [2:0] CMD_CONTACT = 3'd1;
    localparam logic [2:0] CMD_PROBE_OK = 3'd2;
    localparam logic [2:0] CMD_PROBE_MISS = 3'd3;
    localparam logic [2:0] CMD_FILL = 3'd4;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_ALIVE = 2'd1;
    localparam logic [1:0] ST_SUSPECT = 2'd2;
    localparam logic [1:0] ST_DEAD = 2'd3;

    localparam logic [1:0] REG_MY_NODE = 2'd0;
    localparam logic [1:0] REG_GOSSIP_TTL = 2'd1;
    localparam logic [1:0] REG_SUSPECT_ROUNDS = 2'd2;
    localparam logic [1:0] REG_DEAD_ROUNDS = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] node;
        logic [1:0] rumor_state;
        logic [7:0] rumor_incarnation;
    } t_in_item;

    typedef struct packed {
        logic [1:0] state_after;
        logic       accepted;
        logic       changed;
        logic       went_dead;
        logic [7:0] self_incarnation;
        logic       gossip_valid;
        logic [7:0] gossip_node;
        logic [1:0] gossip_state;
        logic [7:0] gossip_incarnation;
        logic       last;
    } t_out_item;

    // Queue entry payload, also the request into the queue unit.
    typedef struct packed {
        logic [7:0] node;
        logic [1:0] state;
        logic [7:0] incarnation;
    } t_qentry;

    // Commands from the sequencer to the queue unit.
    typedef struct packed {
        logic    enq;
        logic    fill;
        t_qentry entry;
        logic [3:0] ttl;
    } t_qcmd;

    // Status from the queue unit: done pulse, and an emitted entry held until taken.
    typedef struct packed {
        logic    done;
        logic    emit;
        t_qentry entry;
    } t_qstat;

    function automatic logic [1:0] severity(input logic [1:0] st);
        case (st)
            ST_DEAD: severity = 2'd2;
            ST_SUSPECT: severity = 2'd1;
            default: severity = 2'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

### src/mge_queue.sv
// Gossip queue: search, evict, emit, compact; one entry per cycle, emits may wait.
`default_nettype none
module mge_queue
    import mge_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qcmd  i_cmd,
    input  wire logic   i_emit_ready,
    output t_qstat      o_stat
);
    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_EVICT, S_WRITE, S_FILL, S_EMIT}
        t_state;

    t_qentry    r_mem [QUEUE_DEPTH];
    logic [3:0] r_rem [QUEUE_DEPTH];

    t_state          r_state;
    logic [QCNT_W-1:0] r_count, r_idx, r_wr, r_tgt;
    logic [QCNT_W-1:0] r_low;
    logic [3:0]      r_low_rem;
    logic [FCNT_W-1:0] r_sent;
    t_qentry         r_req;
    logic [3:0]      r_ttl;
    t_qstat          r_stat;
    logic [QIDX_W-1:0] rd_i, wr_i;
    t_qentry         rd_e;
    logic [3:0]      rd_r, new_r;
    logic            take;

    assign rd_i = r_idx[QIDX_W-1:0];
    assign wr_i = r_wr[QIDX_W-1:0];
    assign rd_e = r_mem[rd_i];
    assign rd_r = r_rem[rd_i];
    // An entry is emitted while the fill limit allows and its TTL is live.
    assign take = (rd_r != 4'd0) && (r_sent < FCNT_W'(FILL_LIM));
    assign new_r = take ? rd_r - 4'd1 : rd_r;
    assign o_stat = r_stat;

    always_ff @(posedge i_clk) begin
        r_stat.done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_stat <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_wr <= '0;
                    r_sent <= '0;
                    r_req <= i_cmd.entry;
                    r_ttl <= i_cmd.ttl;
                    r_stat.emit <= 1'b0;
                    if (i_cmd.enq) r_state <= S_SEARCH;
                    else if (i_cmd.fill) r_state <= S_FILL;
                end
                S_SEARCH: begin
                    if (r_idx == r_count) begin
                        if (r_count < QCNT_W'(QUEUE_DEPTH)) begin
                            r_tgt <= r_count;
                            r_count <= r_count + 1'b1;
                            r_state <= S_WRITE;
                        end else begin
                            r_idx <= QCNT_W'(1);
                            r_low <= '0;
                            r_low_rem <= r_rem[0];
                            r_state <= S_EVICT;
                        end
                    end else if (rd_e.node == r_req.node) begin
                        r_tgt <= r_idx;
                        r_state <= S_WRITE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EVICT: begin
                    if (r_idx == QCNT_W'(QUEUE_DEPTH)) begin
                        r_tgt <= r_low;
                        r_state <= S_WRITE;
                    end else begin
                        if (rd_r < r_low_rem) begin
                            r_low <= r_idx;
                            r_low_rem <= rd_r;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_mem[r_tgt[QIDX_W-1:0]] <= r_req;
                    r_rem[r_tgt[QIDX_W-1:0]] <= r_ttl;
                    r_stat.done <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_FILL: begin
                    if (r_idx == r_count) begin
                        r_count <= r_wr;
                        r_stat.emit <= 1'b0;
                        r_stat.done <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        // Emit and compact in one pass; survivors slide down.
                        if (new_r != 4'd0) begin
                            r_mem[wr_i] <= rd_e;
                            r_rem[wr_i] <= new_r;
                            r_wr <= r_wr + 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                        if (take) begin
                            r_sent <= r_sent + 1'b1;
                            r_stat.emit <= 1'b1;
                            r_stat.entry <= rd_e;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_emit_ready) begin
                        r_stat.emit <= 1'b0;
                        r_state <= S_FILL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/membership_gossip_engine_unit.sv
// Top level of the membership gossip engine: table, sequencer and output stage.
//
// One item is handled at a time, and the input stays stalled from the accepting
// edge until the item's last result has been loaded into the output register.
// A membership command that queues an event also waits while the queue unit
// searches its entries for the node, and a full queue adds an eviction sweep.
// A fill waits while the queue unit walks its entries, emitting up to 8 live ones.
// A stalled receiver adds its stall cycles.
`default_nettype none
module membership_gossip_engine_unit
    import mge_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_data,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_QWAIT, S_FWAIT, S_OUT} t_state;

    t_state     r_state;
    logic [7:0] r_my_node, r_sus_rounds, r_dead_rounds, r_own;
    logic [3:0] r_ttl;
    logic [1:0] r_nst [NODES];
    logic [7:0] r_ninc [NODES];
    logic [7:0] r_miss [NODES];
    t_in_item   r_item;
    logic [1:0] r_old;
    logic [7:0] r_cur_inc, r_cur_miss;
    logic       r_acc;
    t_qcmd      r_qcmd;
    t_qstat     qstat;
    logic       r_fill_any;
    logic       r_fdone;
    t_out_item  r_out;
    logic       r_ovalid;
    logic       out_free;
    logic       node_ok;
    logic [NODE_W-1:0] ni;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data = r_out;
    assign node_ok = (r_item.node < 8'(NODES));
    assign ni = r_item.node[NODE_W-1:0];

    mge_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(r_qcmd),
        .i_emit_ready(out_free && r_state == S_FWAIT), .o_stat(qstat)
    );

    always_ff @(posedge i_clk) begin
        logic [1:0] now;
        logic [7:0] m;
        logic       wins;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_fdone <= 1'b0;
            r_qcmd <= '0;
            r_my_node <= NO_NODE;
            r_ttl <= TTL_AT_RESET;
            r_sus_rounds <= 8'd3;
            r_dead_rounds <= 8'd3;
            r_own <= '0;
            for (int k = 0; k < NODES; k++) begin
                r_nst[k] <= ST_UNKNOWN;
                r_ninc[k] <= '0;
                r_miss[k] <= '0;
            end
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            r_qcmd.enq <= 1'b0;
            r_qcmd.fill <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MY_NODE: r_my_node <= i_cfg_data;
                    REG_GOSSIP_TTL: r_ttl <= i_cfg_data[3:0];
                    REG_SUSPECT_ROUNDS: r_sus_rounds <= i_cfg_data;
                    REG_DEAD_ROUNDS: r_dead_rounds <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_data;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_old <= node_ok ? r_nst[ni] : ST_UNKNOWN;
                    r_cur_inc <= r_ninc[ni];
                    r_cur_miss <= r_miss[ni];
                    r_acc <= 1'b0;
                    r_fill_any <= 1'b0;
                    r_fdone <= 1'b0;
                    r_qcmd.ttl <= r_ttl;
                    if (r_item.command == CMD_FILL) begin
                        r_qcmd.fill <= 1'b1;
                        r_state <= S_FWAIT;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    r_qcmd.entry.node <= r_item.node;
                    r_qcmd.entry.incarnation <= r_cur_inc;
                    case (r_item.command) inside
                        CMD_RUMOR: begin
                            if (r_item.node == r_my_node) begin
                                if (r_item.rumor_state == ST_SUSPECT
                                        || r_item.rumor_state == ST_DEAD) begin
                                    if (r_item.rumor_incarnation >= r_own) begin
                                        r_own <= r_item.rumor_incarnation + 8'd1;
                                        r_qcmd.entry.incarnation
                                            <= r_item.rumor_incarnation + 8'd1;
                                    end else begin
                                        r_own <= r_own + 8'd1;
                                        r_qcmd.entry.incarnation <= r_own + 8'd1;
                                    end
                                    r_qcmd.entry.state <= ST_ALIVE;
                                    r_qcmd.enq <= 1'b1;
                                    r_state <= S_QWAIT;
                                end
                            end else if (node_ok) begin
                                r_qcmd.entry.state <= r_item.rumor_state;
                                r_qcmd.entry.incarnation <= r_item.rumor_incarnation;
                                if (r_old == ST_UNKNOWN && (r_item.rumor_state == ST_ALIVE
                                        || r_item.rumor_state == ST_SUSPECT)) begin
                                    r_nst[ni] <= r_item.rumor_state;
                                    r_miss[ni] <= '0;
                                    r_ninc[ni] <= r_item.rumor_incarnation;
                                    r_acc <= 1'b1;
                                    r_qcmd.enq <= 1'b1;
                                    r_state <= S_QWAIT;
                                end else begin
                                    wins = (r_item.rumor_incarnation != r_cur_inc)
                                        ? (r_item.rumor_incarnation > r_cur_inc)
                                        : (severity(r_item.rumor_state) > severity(r_old));
                                    if (wins) begin
                                        r_ninc[ni] <= r_item.rumor_incarnation;
                                        r_acc <= 1'b1;
                                        if (r_old != r_item.rumor_state) begin
                                            r_nst[ni] <= r_item.rumor_state;
                                            r_qcmd.enq <= 1'b1;
                                            r_state <= S_QWAIT;
                                        end
                                    end
                                end
                            end
                        end
                        CMD_CONTACT, CMD_PROBE_OK: begin
                            if (node_ok && r_item.node != r_my_node
                                    && (r_item.command == CMD_CONTACT
                                        || r_my_node != NO_NODE)) begin
                                r_nst[ni] <= ST_ALIVE;
                                r_miss[ni] <= '0;
                                r_acc <= 1'b1;
                                r_qcmd.entry.state <= ST_ALIVE;
                                if (r_old != ST_ALIVE) begin
                                    r_qcmd.enq <= 1'b1;
                                    r_state <= S_QWAIT;
                                end
                            end
                        end
                        CMD_PROBE_MISS: begin
                            if (node_ok && r_item.node != r_my_node
                                    && r_my_node != NO_NODE) begin
                                m = r_cur_miss + ((r_cur_miss != 8'hFF) ? 8'd1 : 8'd0);
                                r_miss[ni] <= m;
                                r_acc <= 1'b1;
                                if (r_old == ST_ALIVE && m >= r_sus_rounds) begin
                                    r_nst[ni] <= ST_SUSPECT;
                                    r_miss[ni] <= '0;
                                    r_qcmd.entry.state <= ST_SUSPECT;
                                    r_qcmd.enq <= 1'b1;
                                    r_state <= S_QWAIT;
                                end else if (r_old == ST_SUSPECT
                                        && m >= r_dead_rounds) begin
                                    r_nst[ni] <= ST_DEAD;
                                    r_miss[ni] <= '0;
                                    r_qcmd.entry.state <= ST_DEAD;
                                    r_qcmd.enq <= 1'b1;
                                    r_state <= S_QWAIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_QWAIT: begin
                    if (qstat.done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        now = node_ok ? r_nst[ni] : ST_UNKNOWN;
                        r_out <= '0;
                        r_out.state_after <= now;
                        r_out.accepted <= r_acc;
                        r_out.changed <= (now != r_old);
                        r_out.went_dead <= (r_old == ST_SUSPECT) && (now == ST_DEAD);
                        r_out.self_incarnation <= r_own;
                        r_out.last <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_FWAIT: begin
                    // Each emitted entry is held back until the next one or the
                    // end of the walk tells whether it is the last.
                    if ((qstat.done || r_fdone) && out_free) begin
                        r_out <= '0;
                        r_out.self_incarnation <= r_own;
                        r_out.last <= 1'b1;
                        if (r_fill_any) begin
                            r_out.gossip_valid <= 1'b1;
                            r_out.gossip_node <= r_cur_inc;
                            r_out.gossip_state <= r_old;
                            r_out.gossip_incarnation <= r_cur_miss;
                        end
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (qstat.done) begin
                        // The walk has ended while the output register is still full.
                        r_fdone <= 1'b1;
                    end else if (qstat.emit && out_free) begin
                        r_out <= '0;
                        r_out.self_incarnation <= r_own;
                        r_out.gossip_valid <= 1'b1;
                        r_out.gossip_node <= r_cur_inc;
                        r_out.gossip_state <= r_old;
                        r_out.gossip_incarnation <= r_cur_miss;
                        r_cur_inc <= qstat.entry.node;
                        r_old <= qstat.entry.state;
                        r_cur_miss <= qstat.entry.incarnation;
                        r_ovalid <= r_fill_any;
                        r_fill_any <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for the membership gossip engine: directed and random items checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import mge_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    membership_gossip_engine_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_item),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Predictor state.
    logic [7:0] cfg_self;
    logic [3:0] cfg_ttl;
    logic [7:0] cfg_suspect;
    logic [7:0] cfg_dead;
    logic [1:0] tbl_state [NODES];
    logic [7:0] tbl_inc [NODES];
    logic [7:0] tbl_miss [NODES];
    logic [7:0] own_inc;
    logic [7:0] gq_node [QUEUE_DEPTH];
    logic [1:0] gq_state [QUEUE_DEPTH];
    logic [7:0] gq_inc [QUEUE_DEPTH];
    logic [3:0] gq_ttl [QUEUE_DEPTH];
    int         gq_count;

    t_out_item  pending_results[$];
    int         fail_count = 0;
    bit         long_hold = 1'b0;

    function automatic logic [1:0] rank(logic [1:0] st);
        if (st == ST_DEAD) return 2'd2;
        if (st == ST_SUSPECT) return 2'd1;
        return 2'd0;
    endfunction

    function automatic void gq_write(int i, logic [7:0] nd, logic [1:0] st, logic [7:0] inc);
        gq_node[i] = nd;
        gq_state[i] = st;
        gq_inc[i] = inc;
        gq_ttl[i] = cfg_ttl;
    endfunction

    function automatic void gossip_push(logic [7:0] nd, logic [1:0] st, logic [7:0] inc);
        int lo;
        lo = 0;
        for (int i = 0; i < gq_count; i++) begin
            if (gq_node[i] == nd) begin
                gq_write(i, nd, st, inc);
                return;
            end
        end
        if (gq_count < QUEUE_DEPTH) begin
            gq_write(gq_count, nd, st, inc);
            gq_count++;
            return;
        end
        for (int i = 1; i < QUEUE_DEPTH; i++)
            if (gq_ttl[i] < gq_ttl[lo]) lo = i;
        gq_write(lo, nd, st, inc);
    endfunction

    function automatic void predict_fill();
        t_out_item r;
        t_out_item got[$];
        int w;
        w = 0;
        for (int i = 0; i < gq_count && got.size() < FILL_LIM; i++) begin
            if (gq_ttl[i] == 0) continue;
            r = '0;
            r.gossip_valid = 1'b1;
            r.gossip_node = gq_node[i];
            r.gossip_state = gq_state[i];
            r.gossip_incarnation = gq_inc[i];
            got.push_back(r);
            gq_ttl[i]--;
        end
        for (int i = 0; i < gq_count; i++) begin
            if (gq_ttl[i] > 0) begin
                gq_node[w] = gq_node[i];
                gq_state[w] = gq_state[i];
                gq_inc[w] = gq_inc[i];
                gq_ttl[w] = gq_ttl[i];
                w++;
            end
        end
        gq_count = w;
        if (got.size() == 0) begin
            r = '0;
            got.push_back(r);
        end
        got[got.size() - 1].last = 1'b1;
        foreach (got[k]) begin
            got[k].self_incarnation = own_inc;
            pending_results.push_back(got[k]);
        end
    endfunction

    function automatic void predict_membership(t_in_item it);
        t_out_item r;
        logic [1:0] prev;
        logic [7:0] misses;
        bit in_table;
        bit acc;
        bit wins;
        int nd;
        nd = it.node;
        in_table = it.node < NODES;
        prev = in_table ? tbl_state[nd] : ST_UNKNOWN;
        acc = 1'b0;
        if (it.command == CMD_RUMOR) begin
            if (it.node == cfg_self) begin
                if (it.rumor_state == ST_SUSPECT || it.rumor_state == ST_DEAD) begin
                    own_inc = (it.rumor_incarnation >= own_inc) ?
                        it.rumor_incarnation + 8'd1 : own_inc + 8'd1;
                    gossip_push(cfg_self, ST_ALIVE, own_inc);
                end
            end else if (in_table) begin
                if (prev == ST_UNKNOWN &&
                    (it.rumor_state == ST_ALIVE || it.rumor_state == ST_SUSPECT)) begin
                    tbl_state[nd] = it.rumor_state;
                    tbl_miss[nd] = '0;
                    tbl_inc[nd] = it.rumor_incarnation;
                    gossip_push(it.node, it.rumor_state, it.rumor_incarnation);
                    acc = 1'b1;
                end else begin
                    wins = (it.rumor_incarnation != tbl_inc[nd]) ?
                        (it.rumor_incarnation > tbl_inc[nd]) :
                        (rank(it.rumor_state) > rank(prev));
                    if (wins) begin
                        tbl_inc[nd] = it.rumor_incarnation;
                        acc = 1'b1;
                        if (prev != it.rumor_state) begin
                            tbl_state[nd] = it.rumor_state;
                            gossip_push(it.node, it.rumor_state, it.rumor_incarnation);
                        end
                    end
                end
            end
        end else if (it.command == CMD_CONTACT || it.command == CMD_PROBE_OK) begin
            if (in_table && it.node != cfg_self &&
                (it.command == CMD_CONTACT || cfg_self != NO_NODE)) begin
                tbl_state[nd] = ST_ALIVE;
                tbl_miss[nd] = '0;
                if (prev != ST_ALIVE) gossip_push(it.node, ST_ALIVE, tbl_inc[nd]);
                acc = 1'b1;
            end
        end else if (it.command == CMD_PROBE_MISS) begin
            if (in_table && it.node != cfg_self && cfg_self != NO_NODE) begin
                misses = tbl_miss[nd];
                if (misses != 8'hFF) misses++;
                tbl_miss[nd] = misses;
                acc = 1'b1;
                if (prev == ST_ALIVE && misses >= cfg_suspect) begin
                    tbl_state[nd] = ST_SUSPECT;
                    tbl_miss[nd] = '0;
                    gossip_push(it.node, ST_SUSPECT, tbl_inc[nd]);
                end else if (prev == ST_SUSPECT && misses >= cfg_dead) begin
                    tbl_state[nd] = ST_DEAD;
                    tbl_miss[nd] = '0;
                    gossip_push(it.node, ST_DEAD, tbl_inc[nd]);
                end
            end
        end
        r = '0;
        r.state_after = in_table ? tbl_state[nd] : ST_UNKNOWN;
        r.accepted = acc;
        r.changed = r.state_after != prev;
        r.went_dead = prev == ST_SUSPECT && r.state_after == ST_DEAD;
        r.self_incarnation = own_inc;
        r.last = 1'b1;
        pending_results.push_back(r);
    endfunction

    // Drives one item, sometimes after a random gap; the predictor runs on acceptance.
    task automatic send_item(logic [2:0] cmd, logic [7:0] nd, logic [1:0] st, logic [7:0] inc);
        t_in_item it;
        it.command = cmd;
        it.node = nd;
        it.rumor_state = st;
        it.rumor_incarnation = inc;
        if ($urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (it.command == CMD_FILL) predict_fill();
        else predict_membership(it);
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MY_NODE: cfg_self = val;
            REG_GOSSIP_TTL: cfg_ttl = val[3:0];
            REG_SUSPECT_ROUNDS: cfg_suspect = val;
            default: cfg_dead = val;
        endcase
    endtask

    task automatic test_directed();
        // Probes while the own id is unassigned are ignored.
        send_item(CMD_PROBE_MISS, 8'd2, ST_ALIVE, 8'd0);
        send_item(CMD_RUMOR, NO_NODE, ST_SUSPECT, 8'd0);
        send_item(CMD_FILL, 8'd0, ST_UNKNOWN, 8'd0);
        wait_drained();
        write_reg(REG_MY_NODE, 8'd0);
        write_reg(REG_GOSSIP_TTL, 8'd2);
        write_reg(REG_SUSPECT_ROUNDS, 8'd1);
        write_reg(REG_DEAD_ROUNDS, 8'd2);
        send_item(CMD_FILL, 8'd0, ST_UNKNOWN, 8'd0);
        send_item(CMD_RUMOR, 8'd3, ST_DEAD, 8'd5);
        send_item(CMD_RUMOR, 8'd3, ST_ALIVE, 8'd255);
        send_item(CMD_RUMOR, 8'd3, ST_SUSPECT, 8'd255);
        send_item(CMD_RUMOR, 8'd3, ST_SUSPECT, 8'd255);
        send_item(CMD_RUMOR, 8'd3, ST_UNKNOWN, 8'd0);
        send_item(CMD_RUMOR, 8'd0, ST_DEAD, 8'd255);
        send_item(CMD_RUMOR, 8'd0, ST_SUSPECT, 8'd3);
        send_item(CMD_RUMOR, 8'd0, ST_ALIVE, 8'd200);
        send_item(CMD_CONTACT, 8'd4, ST_UNKNOWN, 8'd0);
        send_item(CMD_PROBE_MISS, 8'd4, ST_UNKNOWN, 8'd0);
        send_item(CMD_PROBE_MISS, 8'd4, ST_UNKNOWN, 8'd0);
        send_item(CMD_PROBE_MISS, 8'd4, ST_UNKNOWN, 8'd0);
        send_item(CMD_PROBE_OK, 8'd4, ST_UNKNOWN, 8'd0);
        send_item(CMD_PROBE_MISS, 8'd9, ST_UNKNOWN, 8'd0);
        send_item(CMD_CONTACT, 8'd0, ST_UNKNOWN, 8'd0);
        send_item(CMD_CONTACT, 8'd200, ST_ALIVE, 8'd9);
        send_item(3'd5, 8'd1, ST_ALIVE, 8'd1);
        send_item(3'd7, 8'd255, ST_DEAD, 8'd255);
        send_item(CMD_FILL, 8'd0, ST_UNKNOWN, 8'd0);
        send_item(CMD_FILL, 8'd0, ST_UNKNOWN, 8'd0);
        send_item(CMD_FILL, 8'd0, ST_UNKNOWN, 8'd0);
        wait_drained();
    endtask

    task automatic random_item(bit to_self);
        logic [2:0] cmd;
        logic [7:0] nd;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) cmd = CMD_RUMOR;
        else if (pick < 45) cmd = CMD_CONTACT;
        else if (pick < 55) cmd = CMD_PROBE_OK;
        else if (pick < 78) cmd = CMD_PROBE_MISS;
        else if (pick < 96) cmd = CMD_FILL;
        else cmd = 3'($urandom_range(5, 7));
        nd = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NODES - 1));
        if (to_self && $urandom_range(0, 7) == 0) nd = cfg_self;
        send_item(cmd, nd, 2'($urandom),
            ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6)) : 8'($urandom));
    endtask

    task automatic test_random_phase(logic [7:0] self_id, logic [3:0] ttl,
                                     logic [7:0] sus, logic [7:0] dd, int count);
        write_reg(REG_MY_NODE, self_id);
        write_reg(REG_GOSSIP_TTL, {4'd0, ttl});
        write_reg(REG_SUSPECT_ROUNDS, sus);
        write_reg(REG_DEAD_ROUNDS, dd);
        repeat (count) random_item(1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        repeat (12) send_item(CMD_RUMOR, 8'($urandom_range(1, 15)), ST_ALIVE, 8'($urandom));
        long_hold = 1'b0;
        wait_drained();
    endtask

    // Receiver stall pattern, with a long hold-off on request.
    initial begin
        forever begin
            @(negedge clk);
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                out_stall <= 1'b0;
                wait (!long_hold);
            end else if ($urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        t_out_item exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $realtime, out_item);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_item !== exp_r) begin
                    $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_r, out_item);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        cfg_self = NO_NODE;
        cfg_ttl = TTL_AT_RESET;
        cfg_suspect = 8'd3;
        cfg_dead = 8'd3;
        own_inc = '0;
        gq_count = 0;
        for (int i = 0; i < NODES; i++) begin
            tbl_state[i] = ST_UNKNOWN;
            tbl_inc[i] = '0;
            tbl_miss[i] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        repeat (40) @(negedge clk);
        test_directed();
        test_random_phase(8'd5, 4'd15, 8'd255, 8'd1, 20);
        test_random_phase(8'd255, 4'd1, 8'd2, 8'd255, 15);
        test_backpressure();
        test_random_phase(8'd15, 4'd3, 8'd1, 8'd1, 30);
        test_random_phase(8'd200, 4'd0, 8'd1, 8'd2, 15);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
